// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL; rom_ram_bank_mapper.sv includes them.
// Every property is sampled on clk and switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled clock edge.
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true at a sampled clock edge.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== hdl/rrbm_pkg.sv =====
package rrbm_pkg;

	// Widths of the bus access and of the configuration port.
	localparam int OP_W       = 2;
	localparam int ADDR_W     = 16;
	localparam int DATA_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int ROM_OFF_W  = 23;

	// Bus access codes.
	localparam logic [OP_W-1:0] OP_ROM_READ = 2'd0;
	localparam logic [OP_W-1:0] OP_REG_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_RAM_READ = 2'd2;
	localparam logic [OP_W-1:0] OP_RAM_WRITE = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_BYTES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RUMBLE_FITTED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_FITTED = 3'd5;

	// Upper bounds of the bank register windows in the ROM address space.
	localparam logic [ADDR_W-1:0] REG_RAM_EN_LIMIT = 16'h2000;
	localparam logic [ADDR_W-1:0] REG_BANK_LO_LIMIT = 16'h3000;
	localparam logic [ADDR_W-1:0] REG_BANK_HI_LIMIT = 16'h4000;
	localparam logic [ADDR_W-1:0] REG_RAM_BANK_LIMIT = 16'h6000;

	// Value of the low nibble that enables RAM, and the open bus byte.
	localparam logic [3:0]        RAM_EN_KEY = 4'hA;
	localparam logic [DATA_W-1:0] OPEN_BUS = 8'hFF;

	// Command from the control logic to the RAM store.
	typedef struct packed {
		logic rd;
		logic wr;
	} ram_cmd_t;

endpackage

// ===== hdl/rom_ram_bank_mapper.sv =====
// Cartridge bank controller: takes one bus access per cycle while not stalled (ROM read,
// bank register write, RAM read or RAM write) and returns one result per access, in the
// cycle after its transfer. The result delay is set by the registered read port of the
// internal RAM store; bank registers update at the transfer, so the next access
// already sees them. The RAM store holds RAM_BYTES bytes, needs no clearing after
// reset and must be written before it is read. ROM contents are outside the block: a
// ROM read returns the physical offset and whether it lies inside the configured ROM size.
`include "assert_macros.svh"

module rom_ram_bank_mapper #(
	parameter int RAM_BYTES       = 131072,
	parameter int ROM_OFFSET_BITS = 23
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rrbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rrbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rrbm_pkg::OP_W-1:0]        op,
	input  logic [rrbm_pkg::ADDR_W-1:0]      addr,
	input  logic [rrbm_pkg::DATA_W-1:0]      data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rrbm_pkg::ROM_OFF_W-1:0]   rom_offset,
	output logic                             rom_in_range,
	output logic [rrbm_pkg::DATA_W-1:0]      read_data,
	output logic                             rumble,
	output logic                             save_pending
);

	localparam int AW = $clog2(RAM_BYTES);

	logic                             in_accept;
	logic [rrbm_pkg::ROM_OFF_W-1:0]   rom_offset_d;
	logic                             rom_in_range_d;
	logic                             rumble_d;
	logic                             save_d;
	rrbm_pkg::ram_cmd_t               ram_cmd;
	logic [AW-1:0]                    ram_idx;
	logic [rrbm_pkg::DATA_W-1:0]      ram_rdata;

	logic                             valid_s1;
	logic                             rd_hit_s1;
	logic [rrbm_pkg::ROM_OFF_W-1:0]   rom_offset_s1;
	logic                             rom_in_range_s1;
	logic                             rumble_s1;
	logic                             save_s1;

	// A new access is taken whenever the result stage is empty or drains this cycle.
	assign in_stall = valid_s1 && out_stall;
	assign in_accept = in_valid && !in_stall;

	rrbm_ctrl #(
		.RAM_BYTES      (RAM_BYTES),
		.ROM_OFFSET_BITS(ROM_OFFSET_BITS),
		.AW             (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accept        (in_accept),
		.op            (op),
		.addr          (addr),
		.data          (data),
		.rom_offset_d  (rom_offset_d),
		.rom_in_range_d(rom_in_range_d),
		.rumble_d      (rumble_d),
		.save_d        (save_d),
		.ram_cmd       (ram_cmd),
		.ram_idx       (ram_idx)
	);

	rrbm_ram #(
		.DEPTH(RAM_BYTES),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.cmd  (ram_cmd),
		.idx  (ram_idx),
		.wdata(data),
		.rdata(ram_rdata)
	);

	// Result stage control: it fills on a transfer in and empties on a transfer out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rd_hit_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
			rd_hit_s1 <= ram_cmd.rd;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	// Result stage payload; the RAM read data lines up with it from the store.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			rom_offset_s1 <= rom_offset_d;
			rom_in_range_s1 <= rom_in_range_d;
			rumble_s1 <= rumble_d;
			save_s1 <= save_d;
		end
	end

	assign out_valid = valid_s1;
	assign rom_offset = rom_offset_s1;
	assign rom_in_range = rom_in_range_s1;
	assign read_data = rd_hit_s1 ? ram_rdata : rrbm_pkg::OPEN_BUS;
	assign rumble = rumble_s1;
	assign save_pending = save_s1;

	`ASSERT_NEVER(a_ram_rd_wr_excl, ram_cmd.rd && ram_cmd.wr, "RAM read and write in one cycle")
	`ASSERT_PROP(a_ram_cmd_on_xfer, (ram_cmd.rd || ram_cmd.wr) |-> in_accept, "RAM access without transfer")
	`ASSERT_PROP(a_open_bus, (valid_s1 && !rd_hit_s1) |-> (read_data == rrbm_pkg::OPEN_BUS), "Read data without RAM hit")
	`ASSERT_PROP(a_save_sticky, (valid_s1 && save_s1) |=> (!valid_s1 || save_s1), "Save mark cleared")

endmodule

// ===== hdl/rrbm_ram.sv =====
module rrbm_ram #(
	parameter int DEPTH = 131072,
	parameter int AW    = 17
) (
	input  logic                           clk,
	input  rrbm_pkg::ram_cmd_t             cmd,
	input  logic [AW-1:0]                  idx,
	input  logic [rrbm_pkg::DATA_W-1:0]    wdata,
	output logic [rrbm_pkg::DATA_W-1:0]    rdata
);

	logic [rrbm_pkg::DATA_W-1:0] mem [DEPTH];
	logic [rrbm_pkg::DATA_W-1:0] rdata_q;

	// Single port store: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[idx] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/rrbm_ctrl.sv =====
module rrbm_ctrl #(
	parameter int RAM_BYTES       = 131072,
	parameter int ROM_OFFSET_BITS = 23,
	parameter int AW              = 17
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rrbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rrbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             accept,
	input  logic [rrbm_pkg::OP_W-1:0]        op,
	input  logic [rrbm_pkg::ADDR_W-1:0]      addr,
	input  logic [rrbm_pkg::DATA_W-1:0]      data,
	output logic [rrbm_pkg::ROM_OFF_W-1:0]   rom_offset_d,
	output logic                             rom_in_range_d,
	output logic                             rumble_d,
	output logic                             save_d,
	output rrbm_pkg::ram_cmd_t               ram_cmd,
	output logic [AW-1:0]                    ram_idx
);

	localparam logic [rrbm_pkg::ROM_OFF_W-1:0] ROM_MASK =
		rrbm_pkg::ROM_OFF_W'((24'd1 << ROM_OFFSET_BITS) - 24'd1);
	localparam logic [17:0] RAM_LIMIT = 18'(RAM_BYTES);

	// Configuration registers.
	logic [9:0]  rom_bank_count_q;
	logic [23:0] rom_bytes_q;
	logic [4:0]  ram_bank_count_q;
	logic [17:0] ram_bytes_q;
	logic        rumble_fitted_q;
	logic        ram_fitted_q;

	// Bank controller state.
	logic [7:0]  rom_bank_low_q;
	logic        rom_bank_high_q;
	logic        ram_enable_q;
	logic [3:0]  ram_bank_sel_q;
	logic        rumble_q;
	logic        save_q;

	logic [9:0]  rom_count_m1;
	logic [8:0]  rom_bank;
	logic [rrbm_pkg::ROM_OFF_W-1:0] rom_off;
	logic [4:0]  ram_count_m1;
	logic [3:0]  ram_page;
	logic [16:0] ram_off;
	logic        ram_hit;
	logic        ram_on;
	logic        is_rom_rd;
	logic        is_reg_wr;
	logic        is_ram_rd;
	logic        is_ram_wr;
	logic        bank_sel_wr;

	assign is_rom_rd = (op == rrbm_pkg::OP_ROM_READ);
	assign is_reg_wr = (op == rrbm_pkg::OP_REG_WRITE);
	assign is_ram_rd = (op == rrbm_pkg::OP_RAM_READ);
	assign is_ram_wr = (op == rrbm_pkg::OP_RAM_WRITE);

	// ROM mapping: the low window is bank 0, bit 15 of the address is not decoded.
	always_comb begin
		rom_count_m1 = rom_bank_count_q - 10'd1;
		rom_bank = {rom_bank_high_q, rom_bank_low_q};
		if (rom_bank_count_q != 10'd0) begin
			rom_bank = rom_bank & rom_count_m1[8:0];
		end
		if (addr[14]) begin
			rom_off = {rom_bank, addr[13:0]} & ROM_MASK;
		end else begin
			rom_off = {9'd0, addr[13:0]} & ROM_MASK;
		end
	end

	assign rom_offset_d = is_rom_rd ? rom_off : '0;
	assign rom_in_range_d = is_rom_rd && ({1'b0, rom_off} < rom_bytes_q);

	// RAM mapping and bounds check against both the cartridge size and the store.
	always_comb begin
		ram_count_m1 = ram_bank_count_q - 5'd1;
		ram_page = ram_bank_sel_q;
		if (ram_bank_count_q != 5'd0) begin
			ram_page = ram_page & ram_count_m1[3:0];
		end
		ram_off = {ram_page, addr[12:0]};
		ram_hit = ({1'b0, ram_off} < ram_bytes_q) && ({1'b0, ram_off} < RAM_LIMIT);
	end

	assign ram_on = ram_enable_q && ram_fitted_q;
	assign ram_idx = ram_off[AW-1:0];
	assign ram_cmd.rd = accept && is_ram_rd && ram_on && ram_hit;
	assign ram_cmd.wr = accept && is_ram_wr && ram_on && ram_hit;

	// Values of the rumble bit and the save mark after this access.
	assign bank_sel_wr = is_reg_wr && (addr >= rrbm_pkg::REG_BANK_HI_LIMIT)
		&& (addr < rrbm_pkg::REG_RAM_BANK_LIMIT);
	assign rumble_d = (bank_sel_wr && rumble_fitted_q) ? data[3] : rumble_q;
	assign save_d = save_q || (is_ram_wr && ram_on);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_count_q <= '0;
			rom_bytes_q <= '0;
			ram_bank_count_q <= '0;
			ram_bytes_q <= '0;
			rumble_fitted_q <= 1'b0;
			ram_fitted_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rrbm_pkg::CFG_ROM_BANK_COUNT: rom_bank_count_q <= cfg_data[9:0];
				rrbm_pkg::CFG_ROM_BYTES: rom_bytes_q <= cfg_data;
				rrbm_pkg::CFG_RAM_BANK_COUNT: ram_bank_count_q <= cfg_data[4:0];
				rrbm_pkg::CFG_RAM_BYTES: ram_bytes_q <= cfg_data[17:0];
				rrbm_pkg::CFG_RUMBLE_FITTED: rumble_fitted_q <= cfg_data[0];
				rrbm_pkg::CFG_RAM_FITTED: ram_fitted_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Bank register writes, the rumble bit and the sticky save mark, updated on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_low_q <= '0;
			rom_bank_high_q <= 1'b0;
			ram_enable_q <= 1'b0;
			ram_bank_sel_q <= '0;
			rumble_q <= 1'b0;
			save_q <= 1'b0;
		end else if (accept) begin
			rumble_q <= rumble_d;
			save_q <= save_d;
			if (is_reg_wr) begin
				if (addr < rrbm_pkg::REG_RAM_EN_LIMIT) begin
					ram_enable_q <= (data[3:0] == rrbm_pkg::RAM_EN_KEY);
				end else if (addr < rrbm_pkg::REG_BANK_LO_LIMIT) begin
					rom_bank_low_q <= data;
				end else if (addr < rrbm_pkg::REG_BANK_HI_LIMIT) begin
					rom_bank_high_q <= data[0];
				end else if (addr < rrbm_pkg::REG_RAM_BANK_LIMIT) begin
					if (rumble_fitted_q) begin
						ram_bank_sel_q <= {1'b0, data[2:0]};
					end else begin
						ram_bank_sel_q <= data[3:0];
					end
				end
			end
		end
	end

endmodule

// ===== tb/tb_rom_ram_bank_mapper.sv =====
module tb_rom_ram_bank_mapper;
	import rrbm_pkg::*;

	localparam int STORE_BYTES = 131072;

	// One bus access as it is offered to the block.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} bus_access_t;

	// What the block answers for one access.
	typedef struct packed {
		logic [ROM_OFF_W-1:0] offset;
		logic                 in_range;
		logic [DATA_W-1:0]    rd;
		logic                 rumble;
		logic                 save;
	} access_result_t;

	// Cartridge settings and bank registers.
	typedef struct packed {
		logic [9:0]  rom_count;
		logic [23:0] rom_bytes;
		logic [4:0]  ram_count;
		logic [17:0] ram_bytes;
		logic        rumble_fit;
		logic        ram_fit;
		logic [7:0]  bank_lo;
		logic        bank_hi;
		logic        ram_en;
		logic [3:0]  ram_sel;
		logic        rumble;
		logic        save;
	} bank_state_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [OP_W-1:0]       op = '0;
	logic [ADDR_W-1:0]     addr = '0;
	logic [DATA_W-1:0]     data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [ROM_OFF_W-1:0]  rom_offset;
	logic                  rom_in_range;
	logic [DATA_W-1:0]     read_data;
	logic                  rumble;
	logic                  save_pending;

	// The state seen by accepted transfers, and the state ahead of them as the
	// stimulus is generated.
	bank_state_t    cart_state = '0;
	bank_state_t    queued_state = '0;
	logic [7:0]     ram_image [0:STORE_BYTES-1];
	bit             ram_written [0:STORE_BYTES-1];
	bus_access_t    access_queue [$];
	access_result_t due_results [$];
	bus_access_t    offered;
	access_result_t oldest;
	logic           in_taken = 1'b0;
	bit             calm = 1'b0;
	int             errors = 0;

	rom_ram_bank_mapper uut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// Physical RAM index of an access; returns 1 when it lands inside the RAM.
	function automatic logic ram_slot(input bank_state_t s, input logic [ADDR_W-1:0] a,
			output logic [16:0] idx);
		logic [3:0]  bank;
		logic [4:0]  mask;
		logic [17:0] off;
		bank = s.ram_sel;
		mask = s.ram_count - 5'd1;
		if (s.ram_count != 5'd0) begin
			bank = bank & mask[3:0];
		end
		off = {1'b0, bank, a[12:0]};
		idx = off[16:0];
		return (off < s.ram_bytes) && (off < STORE_BYTES);
	endfunction

	// Register writes and the save mark, which is raised by any enabled RAM write.
	function automatic void update_registers(inout bank_state_t s, input logic [OP_W-1:0] o,
			input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		if (o == OP_REG_WRITE) begin
			if (a < REG_RAM_EN_LIMIT) begin
				s.ram_en = (d[3:0] == RAM_EN_KEY);
			end else if (a < REG_BANK_LO_LIMIT) begin
				s.bank_lo = d;
			end else if (a < REG_BANK_HI_LIMIT) begin
				s.bank_hi = d[0];
			end else if (a < REG_RAM_BANK_LIMIT) begin
				if (s.rumble_fit) begin
					s.rumble = d[3];
					s.ram_sel = {1'b0, d[2:0]};
				end else begin
					s.ram_sel = d[3:0];
				end
			end
		end else if (o == OP_RAM_WRITE && s.ram_en && s.ram_fit) begin
			s.save = 1'b1;
		end
	endfunction

	// Expected answer of the block to one accepted access.
	function automatic access_result_t map_access(inout bank_state_t s,
			input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		access_result_t r;
		logic [16:0]    idx;
		logic [8:0]     bank;
		logic [9:0]     mask;
		r = '0;
		r.rd = OPEN_BUS;
		if (o == OP_ROM_READ) begin
			// Address bit 14 picks the switchable window; bit 15 is not decoded.
			if (!a[14]) begin
				r.offset = {9'd0, a[13:0]};
			end else begin
				bank = {s.bank_hi, s.bank_lo};
				mask = s.rom_count - 10'd1;
				if (s.rom_count != 10'd0) begin
					bank = bank & mask[8:0];
				end
				r.offset = {bank, a[13:0]};
			end
			r.in_range = ({1'b0, r.offset} < s.rom_bytes);
		end else if (o != OP_REG_WRITE && s.ram_en && s.ram_fit && ram_slot(s, a, idx)) begin
			if (o == OP_RAM_READ) begin
				r.rd = ram_image[idx];
			end else begin
				ram_image[idx] = d;
			end
		end
		update_registers(s, o, a, d);
		r.rumble = s.rumble;
		r.save = s.save;
		return r;
	endfunction

	function automatic void set_register(inout bank_state_t s, input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] v);
		case (idx)
			CFG_ROM_BANK_COUNT: s.rom_count = v[9:0];
			CFG_ROM_BYTES: s.rom_bytes = v;
			CFG_RAM_BANK_COUNT: s.ram_count = v[4:0];
			CFG_RAM_BYTES: s.ram_bytes = v[17:0];
			CFG_RUMBLE_FITTED: s.rumble_fit = v[0];
			CFG_RAM_FITTED: s.ram_fit = v[0];
			default: ;
		endcase
	endfunction

	// Queue one access. A RAM read that would land on a byte never written is
	// turned into a write of that byte.
	function automatic void enqueue_access(input logic [OP_W-1:0] o,
			input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		logic [16:0] idx;
		logic        hit;
		bus_access_t item;
		hit = queued_state.ram_en && queued_state.ram_fit && ram_slot(queued_state, a, idx);
		if (o == OP_RAM_READ && hit && !ram_written[idx]) begin
			o = OP_RAM_WRITE;
		end
		if (o == OP_RAM_WRITE && hit) begin
			ram_written[idx] = 1'b1;
		end
		update_registers(queued_state, o, a, d);
		item.op = o;
		item.addr = a;
		item.data = d;
		access_queue.push_back(item);
	endfunction

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < 8);
	endfunction

	task automatic compare_field(input string name, input logic [22:0] want,
			input logic [22:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Wait until every queued access has been transferred and answered. The
	// block has to look idle on several falling edges in a row, so an access
	// that the driver takes from the queue on the same edge is still seen.
	task automatic wait_drained();
		int quiet;
		quiet = 0;
		while (quiet < 3) begin
			@(negedge clk);
			if (access_queue.size() != 0 || in_valid || due_results.size() != 0) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		set_register(cart_state, idx, v);
		set_register(queued_state, idx, v);
		@(negedge clk);
	endtask

	// Reprogram the cartridge once the block has gone quiet.
	task automatic configure(input logic [9:0] rom_count, input logic [23:0] rom_bytes,
			input logic [4:0] ram_count, input logic [17:0] ram_bytes,
			input logic rumble_fit, input logic ram_fit);
		wait_drained();
		write_register(CFG_ROM_BANK_COUNT, CFG_DATA_W'(rom_count));
		write_register(CFG_ROM_BYTES, rom_bytes);
		write_register(CFG_RAM_BANK_COUNT, CFG_DATA_W'(ram_count));
		write_register(CFG_RAM_BYTES, CFG_DATA_W'(ram_bytes));
		write_register(CFG_RUMBLE_FITTED, CFG_DATA_W'(rumble_fit));
		write_register(CFG_RAM_FITTED, CFG_DATA_W'(ram_fit));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Random accesses after a RAM enable. RAM offsets mostly cluster on the first 32 bytes
	// of a bank so that reads find data written earlier.
	task automatic fill_random(input int count);
		int                k;
		int                roll;
		int                region;
		logic [OP_W-1:0]   o;
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		enqueue_access(OP_REG_WRITE, 16'h0000, {4'($urandom_range(15)), RAM_EN_KEY});
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			a = ADDR_W'($urandom);
			d = DATA_W'($urandom);
			if (roll < 25) begin
				o = OP_ROM_READ;
			end else if (roll < 45) begin
				o = OP_REG_WRITE;
				region = $urandom_range(9);
				case (region)
					0, 1: begin
						a = ADDR_W'($urandom_range(16'h1FFF));
						if ($urandom_range(9) < 7) begin
							d[3:0] = RAM_EN_KEY;
						end
					end
					2, 3: a = ADDR_W'($urandom_range(16'h2FFF, 16'h2000));
					4: a = ADDR_W'($urandom_range(16'h3FFF, 16'h3000));
					5, 6: a = ADDR_W'($urandom_range(16'h5FFF, 16'h4000));
					7: a = ADDR_W'($urandom_range(16'hFFFF, 16'h6000));
					default: ;
				endcase
			end else begin
				o = (roll < 72) ? OP_RAM_READ : OP_RAM_WRITE;
				if ($urandom_range(3) != 0) begin
					a[12:0] = 13'($urandom_range(31));
				end
			end
			enqueue_access(o, a, d);
		end
	endtask

	// Driver: offers the next queued access once the previous one was transferred.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= take_break();
			if (!in_valid || in_taken) begin
				if (access_queue.size() != 0 && !take_break()) begin
					offered = access_queue.pop_front();
					in_valid <= 1'b1;
					op <= offered.op;
					addr <= offered.addr;
					data <= offered.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predicts on each input transfer and checks each output transfer.
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				due_results.push_back(map_access(cart_state, op, addr, data));
			end
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: result transfer with none expected", $time);
					errors++;
				end else begin
					oldest = due_results.pop_front();
					compare_field("rom_offset", oldest.offset, rom_offset);
					compare_field("rom_in_range", 23'(oldest.in_range), 23'(rom_in_range));
					compare_field("read_data", 23'(oldest.rd), 23'(read_data));
					compare_field("rumble", 23'(oldest.rumble), 23'(rumble));
					compare_field("save_pending", 23'(oldest.save), 23'(save_pending));
				end
			end
		end
	end

	initial begin
		#1600000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: no RAM fitted, empty ROM, disabled write leaves no mark.
		enqueue_access(OP_ROM_READ, 16'h4123, 8'h00);
		enqueue_access(OP_RAM_WRITE, 16'hA000, 8'h11);
		enqueue_access(OP_RAM_READ, 16'hA000, 8'h00);

		// Full bank counts with the top ROM byte and the top RAM bank outside the range.
		configure(10'd512, 24'h7FFFFF, 5'd16, 18'h1E000, 1'b0, 1'b1);
		enqueue_access(OP_RAM_WRITE, 16'hA000, 8'h22);
		enqueue_access(OP_REG_WRITE, 16'h0000, 8'h1A);
		enqueue_access(OP_RAM_WRITE, 16'hA000, 8'h33);
		enqueue_access(OP_RAM_READ, 16'h2000, 8'h00);
		enqueue_access(OP_REG_WRITE, 16'h2000, 8'hFF);
		enqueue_access(OP_REG_WRITE, 16'h3FFF, 8'h01);
		enqueue_access(OP_ROM_READ, 16'h7FFF, 8'hFF);
		enqueue_access(OP_ROM_READ, 16'hC000, 8'h00);
		enqueue_access(OP_ROM_READ, 16'h8000, 8'h00);
		enqueue_access(OP_ROM_READ, 16'h3FFF, 8'h00);
		enqueue_access(OP_REG_WRITE, 16'h5FFF, 8'h0F);
		enqueue_access(OP_RAM_WRITE, 16'hBFFF, 8'h44);
		enqueue_access(OP_RAM_READ, 16'hBFFF, 8'h00);
		enqueue_access(OP_REG_WRITE, 16'h4000, 8'hFE);
		enqueue_access(OP_RAM_WRITE, 16'hBFFF, 8'h55);
		enqueue_access(OP_RAM_READ, 16'h1FFF, 8'h00);
		enqueue_access(OP_REG_WRITE, 16'h6000, 8'h00);
		enqueue_access(OP_REG_WRITE, 16'hFFFF, 8'h0A);
		enqueue_access(OP_REG_WRITE, 16'h1FFF, 8'hF0);
		enqueue_access(OP_RAM_READ, 16'hA000, 8'h00);
		enqueue_access(OP_REG_WRITE, 16'h0000, 8'h0A);

		// Random phases over a range of cartridges, largest and empty among them.
		configure(10'd512, 24'h800000, 5'd16, 18'h20000, 1'b0, 1'b1);
		fill_random(70);
		configure(10'd0, 24'h000000, 5'd0, 18'h00000, 1'b0, 1'b0);
		fill_random(50);
		configure(10'd64, 24'h100000, 5'd4, 18'h08000, 1'b1, 1'b1);
		fill_random(70);
		// Bank counts that are not powers of two still mask with count minus one.
		configure(10'd96, 24'h180000, 5'd3, 18'h06000, 1'b0, 1'b1);
		fill_random(70);
		configure(10'd1, 24'h007FFF, 5'd1, 18'h02000, 1'b1, 1'b1);
		calm = 1'b1;
		fill_random(70);
		configure(10'd0, 24'h3FFFFF, 5'd0, 18'h1F000, 1'b1, 1'b1);
		calm = 1'b0;
		fill_random(70);

		wait_drained();
		repeat (8) @(negedge clk);
		if (errors == 0 && due_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rrbm_pkg.sv
hdl/rrbm_ram.sv
hdl/rrbm_ctrl.sv
hdl/rom_ram_bank_mapper.sv
tb/tb_rom_ram_bank_mapper.sv
